/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/rfh_pkg.sv */
// Shared types and constants for the ray floor hit checker.
package rfh_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TILE_SIZE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TILE_COUNT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_EVEN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_ODD    = 3'd4;

	// floor side W = tile_count * tile_size
	localparam int W_W = 42;

	// classified ray, front to back
	typedef struct packed {
		logic               miss;
		logic [32:0]        nmag;
		logic [31:0]        dmag;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
	} q_item_t;

	// derived floor settings used by the back end
	typedef struct packed {
		logic [W_W-1:0] w;
		logic [31:0]    ts2;
		logic [23:0]    color_even;
		logic [23:0]    color_odd;
	} floor_cfg_t;

endpackage

/* rtl/ray_floor_hit_checker_shade.sv */
// Top level: ray to checkered floor intersection with config registers.
// Throughput: one ray per cycle unless out_stall holds the output;
//   the 31-stage t divider and the two 11-stage tile dividers are
//   pipelined, one quotient bit per stage.
// Reset: arst_n clears all valid state; registers return to their defaults.
// A four-item queue splits the classifying front from the arithmetic back.
module ray_floor_hit_checker_shade #(
	parameter int FRAC_BITS   = rfh_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = rfh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port
	input  logic                          cfg_we,
	input  logic [rfh_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	// ray input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            origin_x,
	input  logic signed [31:0]            origin_y,
	input  logic signed [31:0]            origin_z,
	input  logic signed [31:0]            dir_x,
	input  logic signed [31:0]            dir_y,
	input  logic signed [31:0]            dir_z,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [30:0]                   distance,
	output logic signed [31:0]            hit_x,
	output logic signed [31:0]            hit_y,
	output logic [10:0]                   tile_col,
	output logic [10:0]                   tile_row,
	output logic [23:0]                   shade
);
	import rfh_pkg::*;

	// config registers
	logic signed [31:0] plane_height_q;
	logic [30:0]        tile_size_q;
	logic [10:0]        tile_count_q;
	logic [23:0]        color_even_q;
	logic [23:0]        color_odd_q;

	// derived: floor side and doubled tile edge, registered to keep the
	// multiplier off the datapath
	logic [W_W-1:0]     w_q;
	logic [31:0]        ts2_q;
	logic [30:0]        ts_eff;

	floor_cfg_t         fcfg;
	q_item_t            f_item;
	q_item_t            q_head;
	logic               f_push;
	logic               q_full;
	logic               q_empty;
	logic               b_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_height_q <= '0;
			tile_size_q    <= 31'd65536;
			tile_count_q   <= 11'd8;
			color_even_q   <= 24'hFFFFFF;
			color_odd_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_HEIGHT: plane_height_q <= cfg_data;
				REG_TILE_SIZE:    tile_size_q    <= cfg_data[30:0];
				REG_TILE_COUNT:   tile_count_q   <= cfg_data[10:0];
				REG_COLOR_EVEN:   color_even_q   <= cfg_data[23:0];
				REG_COLOR_ODD:    color_odd_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// zero tile size behaves as one
	assign ts_eff = (tile_size_q == '0) ? 31'd1 : tile_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= W_W'(524288);
			ts2_q <= 32'd131072;
		end else begin
			w_q   <= W_W'(tile_count_q) * W_W'(ts_eff);
			ts2_q <= {ts_eff, 1'b0};
		end
	end

	assign fcfg.w          = w_q;
	assign fcfg.ts2        = ts2_q;
	assign fcfg.color_even = color_even_q;
	assign fcfg.color_odd  = color_odd_q;

	rfh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.origin_z     (origin_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.plane_height (plane_height_q),
		.queue_full   (q_full),
		.push         (f_push),
		.item         (f_item)
	);

	rfh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_item),
		.pop    (b_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rfh_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.head        (q_head),
		.pop         (b_pop),
		.cfg         (fcfg),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.distance    (distance),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.shade       (shade)
	);

endmodule

/* rtl/rfh_front.sv */
// Front end: accepts rays, computes the numerator and flags early misses.
module rfh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] plane_height,
	input  logic               queue_full,
	output logic               push,
	output rfh_pkg::q_item_t   item
);
	import rfh_pkg::*;

	logic        item_v_s1;
	q_item_t     item_s1;
	q_item_t     cls;
	logic [32:0] num;
	logic        away;

	always_comb begin
		num  = {plane_height[31], plane_height} - {origin_z[31], origin_z};
		away = (num != '0) && (num[32] != dir_z[31]);
		cls.nmag = num[32] ? (~num + 33'd1) : num;
		cls.dmag = dir_z[31] ? (~dir_z + 32'd1) : dir_z;
		cls.miss = (dir_z == '0) || away;
		cls.ox   = origin_x;
		cls.oy   = origin_y;
		cls.dx   = dir_x;
		cls.dy   = dir_y;
	end

	assign in_stall = item_v_s1 && queue_full;
	assign push     = item_v_s1 && !queue_full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

/* rtl/rfh_queue.sv */
// Short queue between front and back ends.
module rfh_queue #(
	parameter int DEPTH = rfh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rfh_pkg::q_item_t wdata,
	input  logic             pop,
	output rfh_pkg::q_item_t rdata,
	output logic             full,
	output logic             empty
);
	import rfh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t         slot_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

/* rtl/rfh_back.sv */
// Back end: pipelined t divider, hit point, square test, tile dividers, output.
module rfh_back #(
	parameter int FRAC_BITS = rfh_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  rfh_pkg::q_item_t    head,
	output logic                pop,
	input  rfh_pkg::floor_cfg_t cfg,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [30:0]         distance,
	output logic signed [31:0]  hit_x,
	output logic signed [31:0]  hit_y,
	output logic [10:0]         tile_col,
	output logic [10:0]         tile_row,
	output logic [23:0]         shade
);
	import rfh_pkg::*;

	localparam int NW = 33 + FRAC_BITS;
	localparam int TQ = 31;
	localparam int CQ = 11;

	typedef struct packed {
		logic               miss;
		logic [31:0]        rem;
		logic [31:0]        dmag;
		logic [TQ-1:0]      nlo;
		logic [TQ-1:0]      q;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
	} div_t;

	typedef struct packed {
		logic               miss;
		logic [TQ-1:0]      t;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [63:0] px;
		logic signed [63:0] py;
	} mul_t;

	typedef struct packed {
		logic               miss;
		logic [TQ-1:0]      t;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
	} pt_t;

	typedef struct packed {
		logic               miss;
		logic [TQ-1:0]      t;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic [31:0]        remx;
		logic [31:0]        remy;
		logic [CQ-1:0]      lox;
		logic [CQ-1:0]      loy;
		logic [CQ-1:0]      qx;
		logic [CQ-1:0]      qy;
	} td_t;

	function automatic div_t div_step(input div_t d);
		logic [32:0] r2;
		div_t        o;
		r2    = {d.rem, d.nlo[TQ-1]};
		o     = d;
		o.nlo = {d.nlo[TQ-2:0], 1'b0};
		if (r2 >= {1'b0, d.dmag}) begin
			o.rem = 32'(r2 - {1'b0, d.dmag});
			o.q   = {d.q[TQ-2:0], 1'b1};
		end else begin
			o.rem = r2[31:0];
			o.q   = {d.q[TQ-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic td_t td_step(input td_t d, input logic [31:0] dv);
		logic [32:0] rx;
		logic [32:0] ry;
		td_t         o;
		rx    = {d.remx, d.lox[CQ-1]};
		ry    = {d.remy, d.loy[CQ-1]};
		o     = d;
		o.lox = {d.lox[CQ-2:0], 1'b0};
		o.loy = {d.loy[CQ-2:0], 1'b0};
		if (rx >= {1'b0, dv}) begin
			o.remx = 32'(rx - {1'b0, dv});
			o.qx   = {d.qx[CQ-2:0], 1'b1};
		end else begin
			o.remx = rx[31:0];
			o.qx   = {d.qx[CQ-2:0], 1'b0};
		end
		if (ry >= {1'b0, dv}) begin
			o.remy = 32'(ry - {1'b0, dv});
			o.qy   = {d.qy[CQ-2:0], 1'b1};
		end else begin
			o.remy = ry[31:0];
			o.qy   = {d.qy[CQ-2:0], 1'b0};
		end
		return o;
	endfunction

	logic en;

	div_t          div_s [TQ+1];
	logic [TQ:0]   div_v_s;
	mul_t          mul_s;
	logic          mul_v_s;
	pt_t           pt_s;
	logic          pt_v_s;
	td_t           td_s [CQ+1];
	logic [CQ:0]   td_v_s;
	logic          out_v_q;

	div_t               div_in;
	logic [NW-1:0]      nfull;
	logic [31:0]        ntop;
	logic signed [63:0] hx64;
	logic signed [63:0] hy64;
	logic               range_ok;
	td_t                td_in;
	logic signed [43:0] sx;
	logic signed [43:0] sy;
	logic               in_square;

	assign en  = !(out_v_q && out_stall);
	assign pop = en && !queue_empty;

	// divider entry: remainder starts at N >> 31; t >= 2^31 iff that is >= dmag
	always_comb begin
		nfull       = {head.nmag, {FRAC_BITS{1'b0}}};
		ntop        = 32'(nfull[NW-1:TQ]);
		div_in.miss = head.miss || (ntop >= head.dmag);
		div_in.rem  = ntop;
		div_in.dmag = head.dmag;
		div_in.nlo  = nfull[TQ-1:0];
		div_in.q    = '0;
		div_in.ox   = head.ox;
		div_in.oy   = head.oy;
		div_in.dx   = head.dx;
		div_in.dy   = head.dy;
	end

	// hit point, floor rounding through arithmetic shift
	always_comb begin
		hx64 = 64'(mul_s.ox) + (mul_s.px >>> FRAC_BITS);
		hy64 = 64'(mul_s.oy) + (mul_s.py >>> FRAC_BITS);
		range_ok = ((&hx64[63:31]) || !(|hx64[63:31])) &&
			((&hy64[63:31]) || !(|hy64[63:31]));
	end

	// square test and tile divider entry on 2*h + W
	always_comb begin
		sx = ($signed({{12{pt_s.hx[31]}}, pt_s.hx}) <<< 1) + $signed({2'b00, cfg.w});
		sy = ($signed({{12{pt_s.hy[31]}}, pt_s.hy}) <<< 1) + $signed({2'b00, cfg.w});
		in_square = !sx[43] && !sy[43] &&
			(sx[42:0] <= {cfg.w, 1'b0}) && (sy[42:0] <= {cfg.w, 1'b0});
		td_in.miss = pt_s.miss || !in_square;
		td_in.t    = pt_s.t;
		td_in.hx   = pt_s.hx;
		td_in.hy   = pt_s.hy;
		td_in.remx = sx[42:CQ];
		td_in.remy = sy[42:CQ];
		td_in.lox  = sx[CQ-1:0];
		td_in.loy  = sy[CQ-1:0];
		td_in.qx   = '0;
		td_in.qy   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s <= '0;
			mul_v_s <= 1'b0;
			pt_v_s  <= 1'b0;
			td_v_s  <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			div_v_s <= {div_v_s[TQ-1:0], pop};
			mul_v_s <= div_v_s[TQ];
			pt_v_s  <= mul_v_s;
			td_v_s  <= {td_v_s[CQ-1:0], pt_v_s};
			out_v_q <= td_v_s[CQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_in;
			for (int k = 1; k <= TQ; k++) begin
				div_s[k] <= div_step(div_s[k-1]);
			end

			mul_s.miss <= div_s[TQ].miss;
			mul_s.t    <= div_s[TQ].q;
			mul_s.ox   <= div_s[TQ].ox;
			mul_s.oy   <= div_s[TQ].oy;
			mul_s.px   <= div_s[TQ].dx * $signed({1'b0, div_s[TQ].q});
			mul_s.py   <= div_s[TQ].dy * $signed({1'b0, div_s[TQ].q});

			pt_s.miss <= mul_s.miss || !range_ok;
			pt_s.t    <= mul_s.t;
			pt_s.hx   <= hx64[31:0];
			pt_s.hy   <= hy64[31:0];

			td_s[0] <= td_in;
			for (int k = 1; k <= CQ; k++) begin
				td_s[k] <= td_step(td_s[k-1], cfg.ts2);
			end

			hit      <= !td_s[CQ].miss;
			distance <= td_s[CQ].miss ? '0 : td_s[CQ].t;
			hit_x    <= td_s[CQ].miss ? '0 : td_s[CQ].hx;
			hit_y    <= td_s[CQ].miss ? '0 : td_s[CQ].hy;
			tile_col <= td_s[CQ].miss ? '0 : td_s[CQ].qx;
			tile_row <= td_s[CQ].miss ? '0 : td_s[CQ].qy;
			if (td_s[CQ].miss) begin
				shade <= '0;
			end else begin
				shade <= (td_s[CQ].qx[0] ^ td_s[CQ].qy[0]) ? cfg.color_odd : cfg.color_even;
			end
		end
	end

	assign out_valid = out_v_q;

endmodule

/* rtl/rfh_checker.sv */
// Port-level checker for the ray floor hit checker, bound to the top level.
`include "assert_macros.svh"

module rfh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic [30:0]        distance,
	input logic signed [31:0] hit_x,
	input logic signed [31:0] hit_y,
	input logic [10:0]        tile_col,
	input logic [10:0]        tile_row,
	input logic [23:0]        shade
);

	// a missed ray reports all-zero fields
	`ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !hit, distance == '0 && hit_x == '0 && hit_y == '0 && tile_col == '0 && tile_row == '0 && shade == '0)

	// the queue only fills up behind a stalled output
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, $past(out_stall))

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(hit) && $stable(distance) && $stable(shade))

endmodule

bind ray_floor_hit_checker_shade rfh_checker u_rfh_checker (.*);

/* tb/testbench.sv */
// Testbench for the ray floor hit checker: directed and random rays against a scoreboard.
`timescale 1ns / 100ps

import rfh_pkg::*;

// expected floor hit results, oldest first
class floor_hit_scoreboard;
	typedef struct {
		logic        hit;
		logic [30:0] distance;
		logic [31:0] hit_x;
		logic [31:0] hit_y;
		logic [10:0] tile_col;
		logic [10:0] tile_row;
		logic [23:0] shade;
	} floor_hit_t;

	floor_hit_t pending[$];
	int errors;

	// floor settings
	logic signed [31:0] plane_z;
	logic [30:0] tile_edge;
	logic [10:0] tiles;
	logic [23:0] even_rgb;
	logic [23:0] odd_rgb;

	function new();
		errors = 0;
		plane_z = 0;
		tile_edge = 31'd65536;
		tiles = 11'd8;
		even_rgb = 24'hFFFFFF;
		odd_rgb = 24'd0;
	endfunction

	function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			REG_PLANE_HEIGHT: plane_z = val;
			REG_TILE_SIZE: tile_edge = val[30:0];
			REG_TILE_COUNT: tiles = val[10:0];
			REG_COLOR_EVEN: even_rgb = val[23:0];
			REG_COLOR_ODD: odd_rgb = val[23:0];
			default: ;
		endcase
	endfunction

	// floor((d * t) / 2^16), rounding toward minus infinity
	function longint scale_dir(longint d, longint t);
		longint prod;
		prod = d * t;
		return prod >>> 16;
	endfunction

	function void note_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
		floor_hit_t r;
		longint num, nmag, dmag, t, hx, hy, ts, w, col, row;
		r = '{default: '0};
		num = longint'(plane_z) - longint'(oz);
		if (dz != 0 && !(num != 0 && ((num < 0) != (dz < 0)))) begin
			nmag = num < 0 ? -num : num;
			dmag = dz < 0 ? -longint'(dz) : longint'(dz);
			t = (nmag << 16) / dmag;
			if (t <= 64'h7FFFFFFF) begin
				hx = longint'(ox) + scale_dir(longint'(dx), t);
				hy = longint'(oy) + scale_dir(longint'(dy), t);
				ts = tile_edge == 0 ? 1 : longint'(tile_edge);
				w = longint'(tiles) * ts;
				if (hx >= -64'sh80000000 && hx <= 64'sh7FFFFFFF &&
						hy >= -64'sh80000000 && hy <= 64'sh7FFFFFFF &&
						2 * hx >= -w && 2 * hx <= w && 2 * hy >= -w && 2 * hy <= w) begin
					col = (2 * hx + w) / (2 * ts);
					row = (2 * hy + w) / (2 * ts);
					r.hit = 1'b1;
					r.distance = t[30:0];
					r.hit_x = hx[31:0];
					r.hit_y = hy[31:0];
					r.tile_col = col[10:0];
					r.tile_row = row[10:0];
					r.shade = ((col + row) & 1) == 0 ? even_rgb : odd_rgb;
				end
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(floor_hit_t got);
		floor_hit_t e;
		if (pending.size() == 0) begin
			$error("unexpected result item");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.hit !== e.hit) begin
			$error("hit exp %0d got %0d", e.hit, got.hit); errors++;
		end
		if (got.distance !== e.distance) begin
			$error("distance exp %h got %h", e.distance, got.distance); errors++;
		end
		if (got.hit_x !== e.hit_x) begin
			$error("hit_x exp %h got %h", e.hit_x, got.hit_x); errors++;
		end
		if (got.hit_y !== e.hit_y) begin
			$error("hit_y exp %h got %h", e.hit_y, got.hit_y); errors++;
		end
		if (got.tile_col !== e.tile_col) begin
			$error("tile_col exp %0d got %0d", e.tile_col, got.tile_col); errors++;
		end
		if (got.tile_row !== e.tile_row) begin
			$error("tile_row exp %0d got %0d", e.tile_row, got.tile_row); errors++;
		end
		if (got.shade !== e.shade) begin
			$error("shade exp %h got %h", e.shade, got.shade); errors++;
		end
	endfunction
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_PLANE_HEIGHT;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [30:0] distance;
	logic signed [31:0] hit_x, hit_y;
	logic [10:0] tile_col, tile_row;
	logic [23:0] shade;

	floor_hit_scoreboard sb = new();
	// idling off for the closing stretch of the run
	bit calm = 1'b0;
	// receiver holds off while this counts down
	int hold_cycles = 0;

	ray_floor_hit_checker_shade uut (.*);

	always #5 clk = ~clk;

	// Result side: sample at rising edge, move stall at the falling edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{hit, distance, hit_x, hit_y, tile_col, tile_row, shade});
	end

	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one ray; called at a falling edge, returns at the falling edge after it is taken.
	task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		do @(posedge clk); while (in_stall);
		sb.note_ray(ox, oy, oz, dx, dy, dz);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [31:0] rnd_fix();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000FFFFF);
			2: return -$urandom_range(0, 32'h000FFFFF);
			3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 4);
			default: return $urandom_range(0, 4) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
		endcase
	endfunction

	// Ray aimed at the floor with a modest slope so most of these hit.
	task automatic send_aimed();
		logic [31:0] oz, dz;
		oz = sb.plane_z + $urandom_range(1, 32'h00080000);
		dz = -$urandom_range(1, 32'h00040000);
		if ($urandom_range(0, 1)) begin
			oz = sb.plane_z - $urandom_range(0, 32'h00080000);
			dz = $urandom_range(1, 32'h00040000);
		end
		send_ray($urandom_range(0, 32'h00080000) - 32'h00040000,
			$urandom_range(0, 32'h00080000) - 32'h00040000, oz,
			$urandom_range(0, 32'h00020000) - 32'h00010000,
			$urandom_range(0, 32'h00020000) - 32'h00010000, dz);
	endtask

	task automatic random_rays(int n);
		repeat (n) begin
			if ($urandom_range(0, 3) != 0) send_aimed();
			else send_ray(rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix(), rnd_fix());
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: default floor is 8 tiles of 1.0, at z = 0.
		send_ray(0, 0, 32'h00010000, 0, 0, 32'hFFFF0000);              // straight down, center
		send_ray(32'h00040000, 32'h00040000, 32'h00010000, 0, 0, -1);  // far corner edge
		send_ray(32'hFFFC0000, 32'hFFFC0000, 32'h00010000, 0, 0, -1);  // near corner edge
		send_ray(32'h00040001, 0, 32'h00010000, 0, 0, -1);             // just outside
		send_ray(0, 0, 32'h00010000, 0, 0, 0);                         // zero dir z
		send_ray(0, 0, 32'h00010000, 0, 0, 32'h00010000);              // pointing away
		send_ray(5, 7, 0, 32'h12345, 0, 32'h00010000);                 // on the plane, t = 0
		send_ray(0, 0, 32'h7FFFFFFF, 0, 0, -1);                        // t overflow
		send_ray(32'h80000000, 0, 32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF);
		send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00020000, 32'h7FFFFFFF, 0, 32'hFFFF0000);
		send_ray(0, 0, 32'h00010000, 32'hFFFF8000, 32'h00018000, 32'hFFFF0000);
		send_ray(32'h00008000, 32'hFFFF8000, 32'h00030000, 32'h00003333, 32'hFFFFCCCD,
			32'hFFFE0000);
		drain();

		// Extremes of the floor settings.
		write_reg(REG_TILE_SIZE, 0);
		write_reg(REG_TILE_COUNT, 0);
		write_reg(REG_PLANE_HEIGHT, 32'h80000000);
		send_ray(0, 0, 32'h80000000, 0, 0, 1);
		send_ray(0, 0, 32'h80000001, 0, 0, 1);
		send_ray(1, 0, 32'h80000000, 0, 0, 1);
		drain();
		write_reg(REG_PLANE_HEIGHT, 32'h7FFFFFFF);
		write_reg(REG_TILE_SIZE, 32'h7FFFFFFF);
		write_reg(REG_TILE_COUNT, 1024);
		write_reg(REG_COLOR_EVEN, 24'h123456);
		write_reg(REG_COLOR_ODD, 24'hFFFFFF);
		send_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 32'h80000000);
		send_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFE, 0, 0, 32'h00010000);
		random_rays(40);
		drain();

		// Random phases with changing settings.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_PLANE_HEIGHT, ph == 0 ? 32'h0 : $urandom_range(0, 32'h00100000) - 32'h00080000);
			write_reg(REG_TILE_SIZE, ph == 1 ? 1 : $urandom_range(32'h1000, 32'h00030000));
			write_reg(REG_TILE_COUNT, ph == 2 ? 1 : $urandom_range(1, 1024));
			write_reg(REG_COLOR_EVEN, $urandom);
			write_reg(REG_COLOR_ODD, ph == 3 ? 0 : $urandom);
			if (ph == 2)
				hold_cycles = 200;   // back pressure fills the block
			random_rays(130);
			drain();                 // sender waits for every result
		end

		calm = 1'b1;
		random_rays(100);
		drain();

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* ray_floor_hit_checker_shade.f */
+incdir+rtl
rtl/rfh_pkg.sv
rtl/rfh_front.sv
rtl/rfh_queue.sv
rtl/rfh_back.sv
rtl/ray_floor_hit_checker_shade.sv
rtl/rfh_checker.sv
tb/testbench.sv
